[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define SRV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define SRV_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define SRV_ASSERT(lbl, prop, msg)
`define SRV_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[sv/srv_pkg.sv]
// ----------------------------------------------------------------------------
// srv_pkg
// Shared constants, types and arithmetic helpers of the reverberator.
// ----------------------------------------------------------------------------
package srv_pkg;

    localparam int COMB_DEPTH = 16384;
    localparam int AP_DEPTH   = 1024;
    localparam int SAMPLE_W   = 24;
    localparam int STORE_W    = 28;
    localparam int GAIN_W     = 16;
    localparam int N_COMB     = 4;
    localparam int N_AP       = 3;

    localparam int CADDR_W    = $clog2(COMB_DEPTH);
    localparam int AADDR_W    = $clog2(AP_DEPTH);
    localparam int CLEN_W     = 15;
    localparam int ALEN_W     = 11;
    localparam int PROD_W     = STORE_W + GAIN_W + 1;
    localparam int WIDE_W     = STORE_W + 2;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int SEC_W      = 2;

    localparam logic [GAIN_W-1:0] COMB_GAIN [N_COMB] = '{
        GAIN_W'(52756), GAIN_W'(54198), GAIN_W'(51315), GAIN_W'(50070)
    };
    localparam logic [CLEN_W-1:0] CLEN_RST [N_COMB] = '{
        CLEN_W'(6920), CLEN_W'(5976), CLEN_W'(7764), CLEN_W'(8624)
    };
    localparam logic [ALEN_W-1:0] ALEN_RST [N_AP] = '{
        ALEN_W'(960), ALEN_W'(322), ALEN_W'(92)
    };
    localparam logic [GAIN_W-1:0] AP_GAIN_RST = GAIN_W'(45875);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COMB0, REG_COMB1, REG_COMB2, REG_COMB3,
        REG_AP0, REG_AP1, REG_AP2, REG_AP_GAIN
    } t_reg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             clear;
        logic             accept;
        logic             rd;
        logic             cmul;
        logic             cwr;
        logic             amul1;
        logic             aout;
        logic             amul2;
        logic             awr;
        logic             load_out;
        logic [SEC_W-1:0] sec;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
    } t_sts;

    // Q0.16 product rounded half up back to the store scale.
    function automatic logic signed [WIDE_W-1:0] gain_round(
        input logic signed [PROD_W-1:0] p
    );
        logic [PROD_W:0] t;
        t = {p[PROD_W-1], p} + (PROD_W+1)'(1 << (GAIN_W - 1));
        return $signed(t[PROD_W:GAIN_W]);
    endfunction

    function automatic logic signed [STORE_W-1:0] sat_store(
        input logic signed [WIDE_W-1:0] v
    );
        logic [WIDE_W-STORE_W:0] top;
        top = v[WIDE_W-1:STORE_W-1];
        if (top == '0 || top == '1) begin
            return v[STORE_W-1:0];
        end else if (v[WIDE_W-1]) begin
            return {1'b1, {(STORE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(STORE_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [STORE_W-1:0] v
    );
        logic [STORE_W-SAMPLE_W:0] top;
        top = v[STORE_W-1:SAMPLE_W-1];
        if (top == '0 || top == '1) begin
            return v[SAMPLE_W-1:0];
        end else if (v[STORE_W-1]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

[sv/srv_ctrl.sv]
// ----------------------------------------------------------------------------
// srv_ctrl
// Sequencer: clearing pass, comb phase, three allpass sections, output load.
// ----------------------------------------------------------------------------
module srv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  srv_pkg::t_sts i_sts,
    output srv_pkg::t_cmd o_cmd
);
    import srv_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CRD, S_CMUL, S_CWR,
        S_AMUL1, S_AOUT, S_AMUL2, S_AWR, S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [SEC_W-1:0] r_sec, n_sec;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sec       <= n_sec;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sec       = r_sec;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.sec   = r_sec;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CRD;
                end
            end
            S_CRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CMUL;
            end
            S_CMUL: begin
                o_cmd.cmul = 1'b1;
                n_state    = S_CWR;
            end
            S_CWR: begin
                // The first allpass product overlaps the comb write-back.
                o_cmd.cwr   = 1'b1;
                o_cmd.amul1 = 1'b1;
                o_cmd.sec   = '0;
                n_sec       = '0;
                n_state     = S_AOUT;
            end
            S_AMUL1: begin
                o_cmd.amul1 = 1'b1;
                n_state     = S_AOUT;
            end
            S_AOUT: begin
                o_cmd.aout = 1'b1;
                n_state    = S_AMUL2;
            end
            S_AMUL2: begin
                o_cmd.amul2 = 1'b1;
                n_state     = S_AWR;
            end
            S_AWR: begin
                o_cmd.awr = 1'b1;
                if (r_sec == SEC_W'(N_AP - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_sec   = r_sec + SEC_W'(1);
                    n_state = S_AMUL1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[sv/srv_datapath.sv]
// ----------------------------------------------------------------------------
// srv_datapath
// Configuration registers, delay line memories, pointers and arithmetic.
// ----------------------------------------------------------------------------
module srv_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [srv_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [srv_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic signed [srv_pkg::SAMPLE_W-1:0]  i_sample_in,
    output logic signed [srv_pkg::SAMPLE_W-1:0]  o_sample_out,
    input  srv_pkg::t_cmd                        i_cmd,
    output srv_pkg::t_sts                        o_sts
);
    import srv_pkg::*;

    logic [CLEN_W-1:0]          r_clen [N_COMB];
    logic [ALEN_W-1:0]          r_alen [N_AP];
    logic [GAIN_W-1:0]          r_ap_gain;

    logic [CADDR_W-1:0]         r_cpos [N_COMB];
    logic [AADDR_W-1:0]         r_apos [N_AP];
    logic [CADDR_W-1:0]         r_clr_addr;

    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [STORE_W-1:0]  r_crd [N_COMB];
    logic signed [STORE_W-1:0]  r_ard [N_AP];
    logic signed [PROD_W-1:0]   r_cprod [N_COMB];
    logic signed [PROD_W-1:0]   r_aprod;
    logic signed [STORE_W-1:0]  r_y;
    logic signed [STORE_W-1:0]  r_apout;
    logic signed [SAMPLE_W-1:0] r_sample_out;

    logic [CADDR_W-1:0]         n_cpos [N_COMB];
    logic [AADDR_W-1:0]         n_apos [N_AP];
    logic signed [WIDE_W-1:0]   comb_sum;
    logic signed [STORE_W-1:0]  ap_stored;
    logic signed [STORE_W-1:0]  mul_a;
    logic signed [STORE_W-1:0]  ap_wdata;

    // Configuration writes; the register index space is fully decoded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_COMB; k++) r_clen[k] <= CLEN_RST[k];
            for (int k = 0; k < N_AP; k++) r_alen[k] <= ALEN_RST[k];
            r_ap_gain <= AP_GAIN_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_COMB0:   r_clen[0] <= i_cfg_wdata[CLEN_W-1:0];
                REG_COMB1:   r_clen[1] <= i_cfg_wdata[CLEN_W-1:0];
                REG_COMB2:   r_clen[2] <= i_cfg_wdata[CLEN_W-1:0];
                REG_COMB3:   r_clen[3] <= i_cfg_wdata[CLEN_W-1:0];
                REG_AP0:     r_alen[0] <= i_cfg_wdata[ALEN_W-1:0];
                REG_AP1:     r_alen[1] <= i_cfg_wdata[ALEN_W-1:0];
                REG_AP2:     r_alen[2] <= i_cfg_wdata[ALEN_W-1:0];
                REG_AP_GAIN: r_ap_gain <= i_cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Pointer advance: zero length acts as one, excess length as the depth.
    always_comb begin
        logic [CLEN_W-1:0] ceff, cnext;
        logic [ALEN_W-1:0] aeff, anext;
        for (int k = 0; k < N_COMB; k++) begin
            if (r_clen[k] == '0) begin
                ceff = CLEN_W'(1);
            end else if (r_clen[k] > CLEN_W'(COMB_DEPTH)) begin
                ceff = CLEN_W'(COMB_DEPTH);
            end else begin
                ceff = r_clen[k];
            end
            cnext     = {1'b0, r_cpos[k]} + CLEN_W'(1);
            n_cpos[k] = (cnext >= ceff) ? '0 : cnext[CADDR_W-1:0];
        end
        for (int k = 0; k < N_AP; k++) begin
            if (r_alen[k] == '0) begin
                aeff = ALEN_W'(1);
            end else if (r_alen[k] > ALEN_W'(AP_DEPTH)) begin
                aeff = ALEN_W'(AP_DEPTH);
            end else begin
                aeff = r_alen[k];
            end
            anext     = {1'b0, r_apos[k]} + ALEN_W'(1);
            n_apos[k] = (anext >= aeff) ? '0 : anext[AADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_COMB; k++) r_cpos[k] <= '0;
            for (int k = 0; k < N_AP; k++) r_apos[k] <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + CADDR_W'(1);
            end
            if (i_cmd.cwr) begin
                for (int k = 0; k < N_COMB; k++) r_cpos[k] <= n_cpos[k];
            end
            if (i_cmd.awr) begin
                for (int k = 0; k < N_AP; k++) begin
                    if (i_cmd.sec == SEC_W'(k)) r_apos[k] <= n_apos[k];
                end
            end
        end
    end

    assign o_sts.clr_done = i_cmd.clear && (r_clr_addr == CADDR_W'(COMB_DEPTH - 1));

    // Comb delay lines, one memory each.
    for (genvar k = 0; k < N_COMB; k++) begin : g_comb
        logic signed [STORE_W-1:0] mem [COMB_DEPTH];
        logic                      we;
        logic [CADDR_W-1:0]        waddr;
        logic signed [STORE_W-1:0] wdata;

        assign we    = i_cmd.clear || i_cmd.cwr;
        assign waddr = i_cmd.clear ? r_clr_addr : r_cpos[k];
        assign wdata = i_cmd.clear ? '0 :
                       sat_store(gain_round(r_cprod[k]) + WIDE_W'(r_x));

        always_ff @(posedge i_clk) begin
            if (we) begin
                mem[waddr] <= wdata;
            end
            if (i_cmd.rd) begin
                r_crd[k] <= mem[r_cpos[k]];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.cmul) begin
                r_cprod[k] <= r_crd[k] * $signed({1'b0, COMB_GAIN[k]});
            end
        end
    end

    // Allpass delay lines, one memory each.
    for (genvar k = 0; k < N_AP; k++) begin : g_ap
        logic signed [STORE_W-1:0] mem [AP_DEPTH];
        logic                      we;
        logic [AADDR_W-1:0]        waddr;

        assign we    = i_cmd.clear || (i_cmd.awr && i_cmd.sec == SEC_W'(k));
        assign waddr = i_cmd.clear ? r_clr_addr[AADDR_W-1:0] : r_apos[k];

        always_ff @(posedge i_clk) begin
            if (we) begin
                mem[waddr] <= i_cmd.clear ? '0 : ap_wdata;
            end
            if (i_cmd.rd) begin
                r_ard[k] <= mem[r_apos[k]];
            end
        end
    end

    always_comb begin
        comb_sum = '0;
        for (int k = 0; k < N_COMB; k++) comb_sum = comb_sum + WIDE_W'(r_crd[k]);
    end

    always_comb begin
        case (i_cmd.sec)
            2'd1:    ap_stored = r_ard[1];
            2'd2:    ap_stored = r_ard[2];
            default: ap_stored = r_ard[0];
        endcase
    end

    assign mul_a    = i_cmd.amul2 ? r_apout : r_y;
    assign ap_wdata = sat_store(gain_round(r_aprod) + WIDE_W'(r_y));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.cmul) begin
            // Floor average of the four comb outputs.
            r_y <= comb_sum[WIDE_W-1:2];
        end else if (i_cmd.awr) begin
            r_y <= r_apout;
        end
        if (i_cmd.amul1 || i_cmd.amul2) begin
            r_aprod <= mul_a * $signed({1'b0, r_ap_gain});
        end
        if (i_cmd.aout) begin
            r_apout <= sat_store(WIDE_W'(ap_stored) - gain_round(r_aprod));
        end
        if (i_cmd.load_out) begin
            r_sample_out <= sat_sample(r_y);
        end
    end

    assign o_sample_out = r_sample_out;

endmodule

[sv/schroeder_reverb_core.sv]
// ----------------------------------------------------------------------------
// schroeder_reverb_core
// Schroeder reverberator: four feedback combs and three series allpasses.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                        Direction
//  --------  ---------------------------------------------  ---------
//  input     i_in_valid, o_in_ready, i_sample_in            in
//  output    o_out_valid, i_out_ready, o_sample_out         out
//  config    i_cfg_wr_en, i_cfg_index, i_cfg_wdata          in
//
//  Items do not overlap: the input closes at a transfer and reopens once the
//  result is loaded into the output register. The sequencer steps are: one
//  read of all delay memories, a comb multiply, a comb write-back that also
//  starts the first allpass product, three more steps for the first allpass
//  section and four for each of the other two through the one shared allpass
//  multiplier, then the output load.
//  After reset a clearing pass zeroes all delay memories; no input transfer is
//  taken meanwhile, configuration writes are.
//  A stalled output holds its result; the next item may be taken meanwhile
//  and waits in its final step until the output register is free.
// ----------------------------------------------------------------------------
module schroeder_reverb_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [srv_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [srv_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [srv_pkg::SAMPLE_W-1:0]  i_sample_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [srv_pkg::SAMPLE_W-1:0]  o_sample_out
);
    import srv_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The controller only sequences; every value lives in the datapath.
    srv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the register file, the seven delay memories with
    // their circular pointers, the comb and allpass multipliers and the
    // output register.
    srv_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

    // No transfer may be taken while the memories are still being cleared.
    `include "assert_macros.svh"
    `SRV_ASSERT_NEVER(a_no_accept_in_clear, cmd.clear && o_in_ready, "input ready while clearing")
    // One item at a time: a transfer closes the input until the item is done.
    `SRV_ASSERT(a_one_item, (i_in_valid && o_in_ready) |=> !o_in_ready, "ready after transfer")
    // A result appears only when the sequencer loads the output register.
    `SRV_ASSERT(a_out_from_load, $rose(o_out_valid) |-> $past(cmd.load_out), "unloaded result")

endmodule

[sim/schroeder_reverb_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// schroeder_reverb_core_test
// Self-checking bench: a directed table of samples and register writes, then
// random phases of audio under random line lengths and gains. Every output
// sample is matched to a typed-in value or to a cycle-free comb/allpass model.
// ----------------------------------------------------------------------------
module schroeder_reverb_core_test;

    import srv_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 7;
    // Margin after the last result before a register write.
    localparam int SETTLE_CYCLES = 20;
    // Long output stall, started once enough results have been checked.
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 400;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 155;
    localparam int PRINT_LIMIT   = 100;
    // Clearing pass plus about a thousand slow items, taken several times over.
    localparam longint TIMEOUT_NS = 64'd4_000_000;

    localparam logic signed [SAMPLE_W-1:0] FULL_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] FULL_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Fixed Q0.16 feedback of the four combs (0.805, 0.827, 0.783, 0.764).
    localparam longint COMB_FEEDBACK [N_COMB] = '{52756, 54198, 51315, 50070};
    localparam int unsigned COMB_LEN_INIT [N_COMB] = '{6920, 5976, 7764, 8624};
    localparam int unsigned AP_LEN_INIT [N_AP] = '{960, 322, 92};
    localparam int unsigned AP_GAIN_INIT = 45875;

    typedef enum {ROW_WRITE, ROW_SAMPLE, ROW_SAMPLE_KNOWN} row_kind_e;
    typedef enum {WAVE_NOISE, WAVE_FULL_SCALE, WAVE_QUIET, WAVE_IMPULSE} wave_style_e;

    typedef struct {
        row_kind_e                    kind;
        t_reg_idx                     reg_sel;
        logic [CFG_W-1:0]             reg_val;
        logic signed [SAMPLE_W-1:0]   dry;
        logic signed [SAMPLE_W-1:0]   want;
    } stim_row_t;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index  = '0;
    logic [CFG_W-1:0]            i_cfg_wdata  = '0;
    logic                        i_in_valid   = 1'b0;
    logic                        o_in_ready;
    logic signed [SAMPLE_W-1:0]  i_sample_in  = '0;
    logic                        o_out_valid;
    logic                        i_out_ready  = 1'b0;
    logic signed [SAMPLE_W-1:0]  o_sample_out;

    schroeder_reverb_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Reverb predictor state: its own copy of the delay lines, pointers and
    // registers. The delay lines are two-state so they start out all zero,
    // matching the clearing pass of the core.
    // ------------------------------------------------------------------------
    bit signed [STORE_W-1:0] comb_store [N_COMB][COMB_DEPTH];
    bit signed [STORE_W-1:0] ap_store [N_AP][AP_DEPTH];
    int unsigned comb_pos [N_COMB];
    int unsigned ap_pos [N_AP];
    int unsigned comb_len [N_COMB] = COMB_LEN_INIT;
    int unsigned ap_len [N_AP] = AP_LEN_INIT;
    int unsigned ap_gain = AP_GAIN_INIT;

    logic signed [SAMPLE_W-1:0] pending_out [$];

    int mismatch_count  = 0;
    int results_checked = 0;
    int samples_sent    = 0;
    int writes_done     = 0;
    int settings_used   = 0;
    int clipped_count   = 0;
    int burst_left      = 0;
    int gap_max         = 0;

    function automatic longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // Q0.16 product, rounded half up. The shift of a signed longint is a floor.
    function automatic longint round_gain(longint v, longint g);
        return (v * g + 64'sd32768) >>> 16;
    endfunction

    // A zero length acts as one; a length past the line's end acts as its depth.
    function automatic int unsigned effective_length(int unsigned len, int unsigned depth);
        if (len == 0) begin
            return 1;
        end else if (len > depth) begin
            return depth;
        end
        return len;
    endfunction

    // Returning to zero on reaching or passing the length also catches a
    // pointer left beyond a length that was just lowered.
    function automatic int unsigned next_position(int unsigned pos, int unsigned len);
        return (pos + 1 >= len) ? 0 : pos + 1;
    endfunction

    function automatic void register_update(t_reg_idx idx, logic [CFG_W-1:0] v);
        case (idx)
            REG_COMB0, REG_COMB1, REG_COMB2, REG_COMB3: begin
                comb_len[int'(idx) - int'(REG_COMB0)] = v[CLEN_W-1:0];
            end
            REG_AP0, REG_AP1, REG_AP2: begin
                ap_len[int'(idx) - int'(REG_AP0)] = v[ALEN_W-1:0];
            end
            REG_AP_GAIN: begin
                ap_gain = v[GAIN_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // One dry sample through four parallel combs, the floor average and three
    // series allpasses; advances the stored state exactly like the core.
    function automatic logic signed [SAMPLE_W-1:0] reverb_predict(
        input logic signed [SAMPLE_W-1:0] dry
    );
        longint x;
        longint sum;
        longint y;
        longint held;
        longint wet;
        longint g;
        int unsigned p;
        x = longint'(dry);
        g = longint'(ap_gain);
        sum = 0;
        for (int k = 0; k < N_COMB; k++) begin
            p = comb_pos[k];
            held = longint'(comb_store[k][p]);
            comb_store[k][p] = STORE_W'(clamp(round_gain(held, COMB_FEEDBACK[k]) + x, STORE_W));
            comb_pos[k] = next_position(p, effective_length(comb_len[k], COMB_DEPTH));
            sum += held;
        end
        y = sum >>> 2;
        for (int k = 0; k < N_AP; k++) begin
            p = ap_pos[k];
            wet = clamp(longint'(ap_store[k][p]) - round_gain(y, g), STORE_W);
            ap_store[k][p] = STORE_W'(clamp(round_gain(wet, g) + y, STORE_W));
            ap_pos[k] = next_position(p, effective_length(ap_len[k], AP_DEPTH));
            y = wet;
        end
        return SAMPLE_W'(clamp(y, SAMPLE_W));
    endfunction

    task automatic report_mismatch(
        input string                      what,
        input logic signed [SAMPLE_W-1:0] got,
        input logic signed [SAMPLE_W-1:0] want
    );
        mismatch_count++;
        // Keep the log readable if the core is badly broken.
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s: sample_out got %0d, expected %0d",
                     $time, what, got, want);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output checker. Every output transfer is matched against the oldest
    // pending expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (pending_out.size() == 0) begin
                report_mismatch("output transfer with nothing pending", o_sample_out, 'x);
            end else if (o_sample_out !== pending_out[0]) begin
                report_mismatch("wrong output sample", o_sample_out, pending_out[0]);
                void'(pending_out.pop_front());
            end else begin
                void'(pending_out.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output ready. The stall pattern switches, window by random window, between
    // always ready, half, mostly stalled and mostly ready. Once, after enough
    // results, the output is held off for a long stretch so the core fills
    // up and backs up into its input.
    // ------------------------------------------------------------------------
    initial begin : out_ready_driver
        int window_left = 0;
        int style = 0;
        bit hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && results_checked >= HOLD_AFTER) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                if (window_left == 0) begin
                    style = $urandom_range(0, 3);
                    window_left = $urandom_range(8, 80);
                end
                window_left--;
                case (style)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 1) == 1);
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side. Items go out in bursts; after each burst the valid drops
    // for a random gap unless the current phase runs without gaps.
    // ------------------------------------------------------------------------
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // Offers one sample and holds it until the transfer. The expectation is
    // the typed-in value where one is given, else the predictor's.
    task automatic send_sample(
        input logic signed [SAMPLE_W-1:0] dry,
        input bit                         known,
        input logic signed [SAMPLE_W-1:0] want
    );
        logic signed [SAMPLE_W-1:0] predicted;
        i_in_valid  <= 1'b1;
        i_sample_in <= dry;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = reverb_predict(dry);
        pending_out.push_back(known ? want : predicted);
        samples_sent++;
        if (predicted == FULL_POS || predicted == FULL_NEG) begin
            clipped_count++;
        end
        pace_sender();
    endtask

    // Registers may only change with no sample inside the core.
    task automatic drain_to_idle();
        i_in_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        register_update(idx, v);
        writes_done++;
        @(posedge i_clk);
    endtask

    // Mostly short lines so feedback builds up within a phase, with the
    // extremes (zero, one, full depth, and past it with high bits set) mixed in.
    function automatic logic [CFG_W-1:0] random_length(int unsigned depth);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_W'(1);
            2: return CFG_W'(depth);
            3: return CFG_W'($urandom_range(depth + 1, 65535));
            4: return CFG_W'($urandom_range(2, depth));
            default: return CFG_W'($urandom_range(2, 48));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    stim_row_t directed_rows [$];

    task automatic add_write(input t_reg_idx idx, input logic [CFG_W-1:0] v);
        stim_row_t row;
        row.kind = ROW_WRITE;
        row.reg_sel = idx;
        row.reg_val = v;
        row.dry = '0;
        row.want = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_sample(input logic signed [SAMPLE_W-1:0] x);
        stim_row_t row;
        row.kind = ROW_SAMPLE;
        row.reg_sel = REG_COMB0;
        row.reg_val = '0;
        row.dry = x;
        row.want = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_known(
        input logic signed [SAMPLE_W-1:0] x,
        input logic signed [SAMPLE_W-1:0] want
    );
        stim_row_t row;
        row.kind = ROW_SAMPLE_KNOWN;
        row.reg_sel = REG_COMB0;
        row.reg_val = '0;
        row.dry = x;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        wave_style_e wave;
        int wave_left;
        bit polarity;
        bit wave_first;
        logic signed [SAMPLE_W-1:0] x;
        logic [CFG_W-1:0] v;

        wave = WAVE_NOISE;
        wave_left = 0;
        polarity = 1'b0;
        wave_first = 1'b0;

        // Right after reset every line is zero and the default comb lengths are
        // thousands of samples, so nothing comes back from the combs yet and
        // the allpasses only pass zeros: all outputs are zero.
        add_known(FULL_POS, '0);
        add_known(FULL_NEG, '0);
        add_known('0, '0);
        add_known(-24'sd1, '0);
        add_known(24'sd1, '0);
        add_known(24'sh555555, '0);
        add_known(24'shAAAAAA, '0);
        add_known(FULL_POS, '0);

        // All pointers now sit at 8. Lowering the lengths below that makes them
        // wrap on the next sample. Also: a zero length, a write whose top bit
        // falls outside the register, and lengths past the line depth.
        add_write(REG_COMB0, 16'd3);
        add_write(REG_COMB1, 16'd0);
        add_write(REG_COMB2, 16'h8002);
        add_write(REG_COMB3, 16'h7FFF);
        add_write(REG_AP0, 16'd0);
        add_write(REG_AP1, 16'hF805);
        add_write(REG_AP2, 16'h07FF);
        add_write(REG_AP_GAIN, 16'hFFFF);

        // Full-scale runs drive the short combs into output clipping.
        repeat (4) add_sample(FULL_POS);
        repeat (4) add_sample(FULL_NEG);
        add_sample('0);
        add_sample(24'sd1);
        add_sample(-24'sd1);
        add_sample(24'sh555555);

        // With zero allpass gain each section turns into a plain delay.
        add_write(REG_AP_GAIN, 16'h0000);
        add_sample(24'sh123456);
        add_sample(-24'sd1);
        add_sample(FULL_POS);
        add_sample(FULL_NEG);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: keep gaps short but present.
        gap_max = 3;
        settings_used = 1;
        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_WRITE: begin
                    if (directed_rows[i - 1].kind != ROW_WRITE) begin
                        drain_to_idle();
                        settings_used++;
                    end
                    write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
                end
                ROW_SAMPLE_KNOWN: send_sample(directed_rows[i].dry, 1'b1,
                                              directed_rows[i].want);
                default: send_sample(directed_rows[i].dry, 1'b0, '0);
            endcase
        end

        // Random phases, each under a fresh register setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_to_idle();
            settings_used++;
            for (int r = int'(REG_COMB0); r <= int'(REG_AP_GAIN); r++) begin
                if (phase == 0 && r != int'(REG_AP_GAIN)) begin
                    // First phase: very short lines and near-unity gain, so
                    // the stores run into their limits.
                    v = CFG_W'($urandom_range(1, 6));
                end else if (phase == 0) begin
                    v = '1;
                end else if (r <= int'(REG_COMB3)) begin
                    v = random_length(COMB_DEPTH);
                end else if (r <= int'(REG_AP2)) begin
                    v = random_length(AP_DEPTH);
                end else begin
                    v = random_gain();
                end
                write_reg(t_reg_idx'(r), v);
            end

            // Some phases run back to back with no idle input cycles.
            case ($urandom_range(0, 3))
                0: gap_max = 0;
                1: gap_max = 3;
                default: gap_max = 20;
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (wave_left == 0) begin
                    wave = wave_style_e'($urandom_range(0, 3));
                    wave_left = $urandom_range(4, 40);
                    polarity = $urandom_range(0, 1);
                    wave_first = 1'b1;
                end
                wave_left--;
                case (wave)
                    WAVE_FULL_SCALE: x = polarity ? FULL_POS : FULL_NEG;
                    WAVE_QUIET: x = SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
                    WAVE_IMPULSE: x = wave_first ? SAMPLE_W'($urandom) : '0;
                    default: x = SAMPLE_W'($urandom);
                endcase
                wave_first = 1'b0;
                send_sample(x, 1'b0, '0);
            end
        end

        drain_to_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d samples under %0d register settings, %0d register writes.",
                 samples_sent, settings_used, writes_done);
        $display("%0d expected samples sat at the clipping limits; output held off %0d cycles once.",
                 clipped_count, HOLD_CYCLES);
        if (mismatch_count == 0 && pending_out.size() == 0) begin
            $display("PASS schroeder_reverb_core");
        end else begin
            $display("FAIL schroeder_reverb_core");
        end
        $finish;
    end

    // Hard stop in case the core hangs.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timed out with %0d samples still pending.", pending_out.size());
        $display("FAIL schroeder_reverb_core");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/srv_pkg.sv
sv/srv_ctrl.sv
sv/srv_datapath.sv
sv/schroeder_reverb_core.sv
sim/schroeder_reverb_core_test.sv
